// ===== rtl/apvt_pkg.sv =====
// ============================================================================
// apvt_pkg: shared types and constants for the affine point/vector transform
// Request codes, register indexes and datapath widths.
// ============================================================================
package apvt_pkg;

    // request codes carried in req_type
    typedef enum logic [1:0] {
        REQ_POINT = 2'd0,
        REQ_DIR   = 2'd1,
        REQ_TDIR  = 2'd2,
        REQ_BOX   = 2'd3
    } req_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_ROW0_LEFT  = 3'd0,
        CFG_ROW0_RIGHT = 3'd1,
        CFG_ROW1_LEFT  = 3'd2,
        CFG_ROW1_RIGHT = 3'd3,
        CFG_ROW2_LEFT  = 3'd4,
        CFG_ROW2_RIGHT = 3'd5
    } cfg_idx_t;

    localparam int unsigned CFG_N = 6;

    // register reset values: identity linear part, zero translation
    localparam logic [63:0] ROW0_LEFT_RST  = 64'h0001_0000_0000_0000;
    localparam logic [63:0] ROW0_RIGHT_RST = 64'h0000_0000_0000_0000;
    localparam logic [63:0] ROW1_LEFT_RST  = 64'h0000_0000_0001_0000;
    localparam logic [63:0] ROW1_RIGHT_RST = 64'h0000_0000_0000_0000;
    localparam logic [63:0] ROW2_LEFT_RST  = 64'h0000_0000_0000_0000;
    localparam logic [63:0] ROW2_RIGHT_RST = 64'h0001_0000_0000_0000;

    // datapath widths: 32x32 products, 3 products + translation, then C +/- H
    localparam int unsigned Q_W    = 32;
    localparam int unsigned PROD_W = 64;
    localparam int unsigned SUM_W  = 66;
    localparam int unsigned OUT_W  = 67;

    localparam logic [Q_W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [Q_W-1:0] Q_MIN = 32'h8000_0000;

endpackage

// ===== rtl/affine_point_vector_transform.sv =====
// ============================================================================
// affine_point_vector_transform: 3x4 affine transform of points, vectors, boxes
// Beats pass decode, product, row-sum, corner, output registers; one beat per
// cycle while not stalled (18 product-stage multipliers, one item per stage).
// Reset clears all stage valid bits and loads the identity matrix.
// Output stall stops the pipeline stage by stage; empty stages still fill.
// ============================================================================
module affine_point_vector_transform #(
    parameter int FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    // configuration write channel
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [63:0]         cfg_data,
    // input channel
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          req_type,
    input  logic signed [31:0]  a_x,
    input  logic signed [31:0]  a_y,
    input  logic signed [31:0]  a_z,
    input  logic signed [31:0]  b_x,
    input  logic signed [31:0]  b_y,
    input  logic signed [31:0]  b_z,
    // output channel
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  r_x,
    output logic signed [31:0]  r_y,
    output logic signed [31:0]  r_z,
    output logic signed [31:0]  s_x,
    output logic signed [31:0]  s_y,
    output logic signed [31:0]  s_z,
    output logic                overflow
);

    localparam int unsigned QW = apvt_pkg::Q_W;
    localparam int unsigned PW = apvt_pkg::PROD_W;
    localparam int unsigned SW = apvt_pkg::SUM_W;
    localparam int unsigned OW = apvt_pkg::OUT_W;

    // shift right by FRAC_BITS (floor) and clamp to 32 bits; bit 32 flags clamp
    function automatic logic [QW:0] sat_q(input logic signed [OW-1:0] v);
        logic signed [OW-1:0] sh;
        logic [QW:0]          res;
        sh = v >>> FRAC_BITS;
        if ((~|sh[OW-1:QW-1]) || (&sh[OW-1:QW-1]))
        begin
            res = {1'b0, sh[QW-1:0]};
        end
        else if (sh[OW-1])
        begin
            res = {1'b1, apvt_pkg::Q_MIN};
        end
        else
        begin
            res = {1'b1, apvt_pkg::Q_MAX};
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [63:0] cfg_reg [apvt_pkg::CFG_N];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[0] <= apvt_pkg::ROW0_LEFT_RST;
            cfg_reg[1] <= apvt_pkg::ROW0_RIGHT_RST;
            cfg_reg[2] <= apvt_pkg::ROW1_LEFT_RST;
            cfg_reg[3] <= apvt_pkg::ROW1_RIGHT_RST;
            cfg_reg[4] <= apvt_pkg::ROW2_LEFT_RST;
            cfg_reg[5] <= apvt_pkg::ROW2_RIGHT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (apvt_pkg::cfg_idx_t'(cfg_index))
                apvt_pkg::CFG_ROW0_LEFT:  cfg_reg[0] <= cfg_data;
                apvt_pkg::CFG_ROW0_RIGHT: cfg_reg[1] <= cfg_data;
                apvt_pkg::CFG_ROW1_LEFT:  cfg_reg[2] <= cfg_data;
                apvt_pkg::CFG_ROW1_RIGHT: cfg_reg[3] <= cfg_data;
                apvt_pkg::CFG_ROW2_LEFT:  cfg_reg[4] <= cfg_data;
                apvt_pkg::CFG_ROW2_RIGHT: cfg_reg[5] <= cfg_data;
                default: ;
            endcase
        end
    end

    // matrix entries, column 3 is the translation
    logic signed [QW-1:0] mat [3][4];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            mat[r][0] = cfg_reg[2*r][63:32];
            mat[r][1] = cfg_reg[2*r][31:0];
            mat[r][2] = cfg_reg[2*r+1][63:32];
            mat[r][3] = cfg_reg[2*r+1][31:0];
        end
    end

    // ------------------------------------------------------------------
    // pipeline flow control: a stage loads when empty or moving on
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;

    assign en5      = !v5_reg || !out_stall;
    assign en4      = !v4_reg || en5;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_stall = !en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: decode request, box center and half extent, operand select
    // ------------------------------------------------------------------
    logic signed [QW-1:0] a_vec [3];
    logic signed [QW-1:0] b_vec [3];
    logic signed [QW:0]   ab_sum [3];
    logic signed [QW:0]   ab_dif [3];
    logic                 is_box, is_tdir, use_t;

    logic signed [QW-1:0] mv_next [3][3];
    logic [QW-1:0]        ma_next [3][3];
    logic signed [QW-1:0] vv_next [3];
    logic signed [QW-1:0] hv_next [3];
    logic signed [QW-1:0] t_next  [3];

    logic signed [QW-1:0] mv_reg [3][3];
    logic [QW-1:0]        ma_reg [3][3];
    logic signed [QW-1:0] vv_reg [3];
    logic signed [QW-1:0] hv_reg [3];
    logic signed [QW-1:0] t1_reg [3];
    logic                 box1_reg;

    assign a_vec[0] = a_x;
    assign a_vec[1] = a_y;
    assign a_vec[2] = a_z;
    assign b_vec[0] = b_x;
    assign b_vec[1] = b_y;
    assign b_vec[2] = b_z;

    always_comb
    begin
        case (apvt_pkg::req_t'(req_type))
            apvt_pkg::REQ_POINT:
            begin
                is_box = 1'b0; is_tdir = 1'b0; use_t = 1'b1;
            end
            apvt_pkg::REQ_DIR:
            begin
                is_box = 1'b0; is_tdir = 1'b0; use_t = 1'b0;
            end
            apvt_pkg::REQ_TDIR:
            begin
                is_box = 1'b0; is_tdir = 1'b1; use_t = 1'b0;
            end
            apvt_pkg::REQ_BOX:
            begin
                is_box = 1'b1; is_tdir = 1'b0; use_t = 1'b1;
            end
            default:
            begin
                is_box = 1'b0; is_tdir = 1'b0; use_t = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            // 33-bit sum and difference, halved with floor
            ab_sum[i] = (QW+1)'(a_vec[i]) + (QW+1)'(b_vec[i]);
            ab_dif[i] = (QW+1)'(b_vec[i]) - (QW+1)'(a_vec[i]);
            vv_next[i] = is_box ? ab_sum[i][QW:1] : a_vec[i];
            hv_next[i] = is_box ? ab_dif[i][QW:1] : '0;
            t_next[i]  = use_t ? mat[i][3] : '0;
        end
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                mv_next[r][c] = is_tdir ? mat[c][r] : mat[r][c];
                // most negative entry becomes 2^31 as unsigned
                ma_next[r][c] = mat[r][c][QW-1] ? (~mat[r][c] + 1'b1) : mat[r][c];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            mv_reg   <= mv_next;
            ma_reg   <= ma_next;
            vv_reg   <= vv_next;
            hv_reg   <= hv_next;
            t1_reg   <= t_next;
            box1_reg <= is_box;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: products, M*v and |M|*h (h is zero outside box requests)
    // ------------------------------------------------------------------
    logic signed [PW-1:0] pc_next [3][3];
    logic signed [PW-1:0] ph_next [3][3];
    logic signed [PW-1:0] pc_reg  [3][3];
    logic signed [PW-1:0] ph_reg  [3][3];
    logic signed [QW-1:0] t2_reg  [3];
    logic                 box2_reg;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                pc_next[r][c] = PW'(mv_reg[r][c] * vv_reg[c]);
                ph_next[r][c] = PW'($signed({1'b0, ma_reg[r][c]}) * hv_reg[c]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            pc_reg   <= pc_next;
            ph_reg   <= ph_next;
            t2_reg   <= t1_reg;
            box2_reg <= box1_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: row sums, C = M*v + t and H = |M|*h
    // ------------------------------------------------------------------
    logic signed [SW-1:0] tw      [3];
    logic signed [SW-1:0] c_next  [3];
    logic signed [SW-1:0] h_next  [3];
    logic signed [SW-1:0] c_reg   [3];
    logic signed [SW-1:0] h_reg   [3];
    logic                 box3_reg;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            tw[r]     = SW'(t2_reg[r]) <<< FRAC_BITS;
            c_next[r] = SW'(pc_reg[r][0]) + SW'(pc_reg[r][1]) + SW'(pc_reg[r][2]) + tw[r];
            h_next[r] = SW'(ph_reg[r][0]) + SW'(ph_reg[r][1]) + SW'(ph_reg[r][2]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            c_reg    <= c_next;
            h_reg    <= h_next;
            box3_reg <= box2_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: low and high corners, C - H and C + H
    // ------------------------------------------------------------------
    logic signed [OW-1:0] lo_reg [3];
    logic signed [OW-1:0] hi_reg [3];
    logic                 box4_reg;

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            for (int r = 0; r < 3; r++)
            begin
                lo_reg[r] <= OW'(c_reg[r]) - OW'(h_reg[r]);
                hi_reg[r] <= OW'(c_reg[r]) + OW'(h_reg[r]);
            end
            box4_reg <= box3_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: shift, saturate, output register
    // ------------------------------------------------------------------
    logic [QW:0]          lo_sat [3];
    logic [QW:0]          hi_sat [3];
    logic signed [QW-1:0] r_next [3];
    logic signed [QW-1:0] s_next [3];
    logic                 ovf_next;

    always_comb
    begin
        ovf_next = 1'b0;
        for (int r = 0; r < 3; r++)
        begin
            lo_sat[r] = sat_q(lo_reg[r]);
            hi_sat[r] = sat_q(hi_reg[r]);
            r_next[r] = lo_sat[r][QW-1:0];
            s_next[r] = box4_reg ? hi_sat[r][QW-1:0] : '0;
            ovf_next  = ovf_next | lo_sat[r][QW] | (box4_reg & hi_sat[r][QW]);
        end
    end

    logic signed [QW-1:0] r_reg [3];
    logic signed [QW-1:0] s_reg [3];
    logic                 ovf_reg;

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            r_reg   <= r_next;
            s_reg   <= s_next;
            ovf_reg <= ovf_next;
        end
    end

    assign out_valid = v5_reg;
    assign r_x       = r_reg[0];
    assign r_y       = r_reg[1];
    assign r_z       = r_reg[2];
    assign s_x       = s_reg[0];
    assign s_y       = s_reg[1];
    assign s_z       = s_reg[2];
    assign overflow  = ovf_reg;

endmodule

// ===== rtl/apvt_checker.sv =====
// ============================================================================
// apvt_props: port-level checks for the affine point/vector transform
// Handshake hold rules, stall relief and pipeline latency.
// ============================================================================
module apvt_props (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic signed [31:0]  r_x,
    input  logic signed [31:0]  s_x,
    input  logic                overflow
);

    // a stalled output beat stays
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
    else $error("output beat dropped while stalled");

    // a stalled output beat keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(r_x) && $stable(s_x) && $stable(overflow))
    else $error("output payload changed while stalled");

    // with the output side free, every stage moves and the input is never stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
    else $error("input stalled although output is not");

    // an accepted beat reaches the output if the output is not stalled on its way through
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall
            ##1 !out_stall |=> out_valid)
    else $error("accepted beat did not appear at the output in time");

endmodule

bind affine_point_vector_transform apvt_props u_apvt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .r_x       (r_x),
    .s_x       (s_x),
    .overflow  (overflow)
);
